@@ hdl/pss_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types and constants of the positional sequence store: store size,
// command and status codes, controller states and the result record.
// ----------------------------------------------------------------------------
package pss_pkg;

   localparam int DEPTH  = 32;
   localparam int DATA_W = 32;
   localparam int POS_W  = 6;
   localparam int LEN_W  = 6;
   localparam int AW     = $clog2(DEPTH);
   localparam int CW     = $clog2(DEPTH + 1);
   // compare width that holds both a position and count + 1
   localparam int CMPW   = (CW + 1 > POS_W) ? CW + 1 : POS_W;

   typedef enum logic [2:0] {
      CMD_INS_FRONT = 3'd0,
      CMD_INS_BACK  = 3'd1,
      CMD_INS_AT    = 3'd2,
      CMD_DEL_FRONT = 3'd3,
      CMD_DEL_BACK  = 3'd4,
      CMD_DEL_AT    = 3'd5,
      CMD_COUNT     = 3'd6,
      CMD_DUMP      = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_SHIFT,
      S_INS_PUT,
      S_DEL_SHIFT,
      S_DUMP
   } state_type;

   typedef struct packed {
      status_type                status;
      logic [LEN_W-1:0]          length;
      logic signed [DATA_W-1:0]  element;
      logic                      element_valid;
      logic                      last;
   } rsp_type;

endpackage
`default_nettype wire

@@ hdl/pss_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pss_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module pss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

@@ hdl/pss_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pss_ctrl
// Command sequencer: decodes a transaction, checks position and fill level,
// and moves entries through the store RAM one per cycle for shifts and dumps.
// ----------------------------------------------------------------------------
module pss_ctrl (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [2:0]                         command,
   input  wire logic signed [pss_pkg::DATA_W-1:0]  value,
   input  wire logic [pss_pkg::POS_W-1:0]          position,
   output logic                                    busy,
   output logic                                    mem_we,
   output logic [pss_pkg::AW-1:0]                  mem_waddr,
   output logic [pss_pkg::DATA_W-1:0]              mem_wdata,
   output logic [pss_pkg::AW-1:0]                  mem_raddr,
   input  wire logic [pss_pkg::DATA_W-1:0]         mem_rdata,
   output logic                                    rsp_fire,
   output pss_pkg::rsp_type                        rsp
);

   import pss_pkg::*;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             ptr_ff, ptr_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic signed [DATA_W-1:0]  val_ff, val_in;

   cmd_type          cmd;
   logic [CMPW-1:0]  cnt_c, pos_c;
   logic             ins_pos_ok, del_pos_ok, full, empty;
   logic [CW-1:0]    pos_idx, cnt_m1, ins_idx, del_idx, del_idx_p1;
   logic [CW-1:0]    ptr_m1, ptr_m2, ptr_p1, ptr_p2;

   assign cmd        = cmd_type'(command);
   assign cnt_c      = CMPW'(count_ff);
   assign pos_c      = CMPW'(position);
   assign ins_pos_ok = (pos_c != '0) && (pos_c <= cnt_c + CMPW'(1));
   assign del_pos_ok = (pos_c != '0) && (pos_c <= cnt_c);
   assign pos_idx    = CW'(pos_c - CMPW'(1));
   assign full       = (count_ff == CW'(DEPTH));
   assign empty      = (count_ff == '0);
   assign cnt_m1     = count_ff - CW'(1);
   assign ins_idx    = (cmd == CMD_INS_FRONT) ? '0 :
                       (cmd == CMD_INS_BACK)  ? count_ff : pos_idx;
   assign del_idx    = (cmd == CMD_DEL_FRONT) ? '0 :
                       (cmd == CMD_DEL_BACK)  ? cnt_m1 : pos_idx;
   assign del_idx_p1 = del_idx + CW'(1);
   assign ptr_m1     = ptr_ff - CW'(1);
   assign ptr_m2     = ptr_ff - CW'(2);
   assign ptr_p1     = ptr_ff + CW'(1);
   assign ptr_p2     = ptr_ff + CW'(2);

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      val_ff <= val_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      idx_in    = idx_ff;
      val_in    = val_ff;
      mem_we    = 1'b0;
      mem_waddr = ptr_ff[AW-1:0];
      mem_wdata = mem_rdata;
      mem_raddr = '0;
      rsp_fire  = 1'b0;
      rsp.status        = ST_OK;
      rsp.element       = '0;
      rsp.element_valid = 1'b0;
      rsp.last          = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (cmd) inside
                  CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
                     if (cmd == CMD_INS_AT && !ins_pos_ok) begin
                        rsp.status = ST_BADPOS;
                        rsp_fire   = 1'b1;
                     end else if (full) begin
                        rsp.status = ST_FULL;
                        rsp_fire   = 1'b1;
                     end else if (ins_idx == count_ff) begin
                        // append: nothing to move
                        mem_we    = 1'b1;
                        mem_waddr = ins_idx[AW-1:0];
                        mem_wdata = value;
                        count_in  = count_ff + CW'(1);
                        rsp_fire  = 1'b1;
                     end else begin
                        mem_raddr = cnt_m1[AW-1:0];
                        ptr_in    = count_ff;
                        idx_in    = ins_idx;
                        val_in    = value;
                        state_in  = S_INS_SHIFT;
                     end
                  end
                  CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
                     if (empty) begin
                        rsp.status = ST_EMPTY;
                        rsp_fire   = 1'b1;
                     end else if (cmd == CMD_DEL_AT && !del_pos_ok) begin
                        rsp.status = ST_BADPOS;
                        rsp_fire   = 1'b1;
                     end else if (del_idx == cnt_m1) begin
                        count_in = cnt_m1;
                        rsp_fire = 1'b1;
                     end else begin
                        mem_raddr = del_idx_p1[AW-1:0];
                        ptr_in    = del_idx;
                        state_in  = S_DEL_SHIFT;
                     end
                  end
                  CMD_COUNT: begin
                     rsp_fire = 1'b1;
                  end
                  CMD_DUMP: begin
                     if (empty) begin
                        rsp.status = ST_EMPTY;
                        rsp_fire   = 1'b1;
                     end else begin
                        mem_raddr = '0;
                        ptr_in    = '0;
                        state_in  = S_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_INS_SHIFT: begin
            // entry ptr-1 arrives from the RAM and moves up into ptr
            mem_we    = 1'b1;
            mem_waddr = ptr_ff[AW-1:0];
            mem_wdata = mem_rdata;
            ptr_in    = ptr_m1;
            if (ptr_m1 == idx_ff) begin
               state_in = S_INS_PUT;
            end else begin
               mem_raddr = ptr_m2[AW-1:0];
            end
         end

         S_INS_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[AW-1:0];
            mem_wdata = val_ff;
            count_in  = count_ff + CW'(1);
            rsp_fire  = 1'b1;
            state_in  = S_IDLE;
         end

         S_DEL_SHIFT: begin
            // entry ptr+1 arrives from the RAM and moves down into ptr
            mem_we    = 1'b1;
            mem_waddr = ptr_ff[AW-1:0];
            mem_wdata = mem_rdata;
            if (ptr_p2 < count_ff) begin
               mem_raddr = ptr_p2[AW-1:0];
               ptr_in    = ptr_p1;
            end else begin
               count_in = cnt_m1;
               rsp_fire = 1'b1;
               state_in = S_IDLE;
            end
         end

         S_DUMP: begin
            rsp_fire          = 1'b1;
            rsp.element       = mem_rdata;
            rsp.element_valid = 1'b1;
            rsp.last          = (ptr_ff == cnt_m1);
            if (ptr_ff == cnt_m1) begin
               state_in = S_IDLE;
            end else begin
               mem_raddr = ptr_p1[AW-1:0];
               ptr_in    = ptr_p1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp.length = LEN_W'(count_in);
   end

endmodule
`default_nettype wire

@@ hdl/positional_sequence_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_sequence_store
// Ordered store of signed 32-bit values with positional insert and delete,
// count and dump commands, kept in a single RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken on a rising edge with start high
//   and busy low. req_command selects the operation, req_value is the value
//   to insert and req_position the 1-based position for insert/delete at.
//   Result channel: each result shows for one cycle with rsp_strobe high;
//   the receiver cannot stall it. rsp_last marks the final result of a
//   command, rsp_length gives the count after the command.
// Operations (i = 0-based target position):
//   errors, count, append and delete of the back entry move no entries;
//   the result follows in the next cycle.
//   insert with shift moves the entries from i on up one place and then
//   writes the value at i; delete with shift moves the entries after i down.
//   dump: busy while the entries are read out, one result per cycle.
//   Entries move one per cycle through the RAM's single write port.
// Reset: synchronous; empties the store, no result is pending afterwards.
// ----------------------------------------------------------------------------
module positional_sequence_store (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [2:0]                         req_command,
   input  wire logic signed [pss_pkg::DATA_W-1:0]  req_value,
   input  wire logic [pss_pkg::POS_W-1:0]          req_position,
   output logic                                    rsp_strobe,
   output logic [1:0]                              rsp_status,
   output logic [pss_pkg::LEN_W-1:0]               rsp_length,
   output logic signed [pss_pkg::DATA_W-1:0]       rsp_element,
   output logic                                    rsp_element_valid,
   output logic                                    rsp_last
);

   import pss_pkg::*;

   logic               mem_we;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic [DATA_W-1:0]  mem_wdata, mem_rdata;
   logic               rsp_fire;
   rsp_type            rsp_next;

   logic     rsp_strobe_ff;
   rsp_type  rsp_ff;

   pss_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   pss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .command   (req_command),
      .value     (req_value),
      .position  (req_position),
      .busy      (busy),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata),
      .rsp_fire  (rsp_fire),
      .rsp       (rsp_next)
   );

   // result output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_length        = rsp_ff.length;
   assign rsp_element       = rsp_ff.element;
   assign rsp_element_valid = rsp_ff.element_valid;
   assign rsp_last          = rsp_ff.last;

endmodule
`default_nettype wire

@@ hdl/pss_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pss_checker
// Port-level checks of the positional sequence store, bound to the top level.
// ----------------------------------------------------------------------------
module pss_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic                               busy,
   input  wire logic [2:0]                         req_command,
   input  wire logic                               rsp_strobe,
   input  wire logic [1:0]                         rsp_status,
   input  wire logic [pss_pkg::LEN_W-1:0]          rsp_length,
   input  wire logic signed [pss_pkg::DATA_W-1:0]  rsp_element,
   input  wire logic                               rsp_element_valid,
   input  wire logic                               rsp_last
);

   import pss_pkg::*;

   // reset leaves the block idle with nothing on the result channel
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !busy && !rsp_strobe)
      else $error("result or busy right after reset");

   // a count transaction answers in the very next cycle
   a_count_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_command == CMD_COUNT
      |=> rsp_strobe && rsp_last && rsp_status == ST_OK && !rsp_element_valid)
      else $error("count transaction not answered next cycle");

   a_full_length: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_FULL |-> rsp_length == LEN_W'(DEPTH))
      else $error("full status with store not full");

   a_empty_length: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_EMPTY |-> rsp_length == '0)
      else $error("empty status with elements held");

   // non-element results are final and carry a zero element
   a_plain_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_element_valid |-> rsp_last && rsp_element == '0)
      else $error("malformed non-element result");

endmodule

bind positional_sequence_store pss_checker u_pss_checker (.*);
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for positional_sequence_store. A queue-fed driver sends
// insert, delete, count and dump transactions; the monitor keeps a shadow copy
// of the sequence, predicts every result and compares each strobed result
// with the oldest prediction. A directed opening is followed by random
// transactions that grow and shrink the store between empty and full.
// ----------------------------------------------------------------------------
module tb_top;
   import pss_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 40;

   typedef struct {
      cmd_type                  command;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
   } seq_cmd_type;

   logic                     clock        = 1'b0;
   logic                     reset        = 1'b1;
   logic                     start        = 1'b0;
   logic [2:0]               req_command  = '0;
   logic signed [DATA_W-1:0] req_value    = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic                     busy;
   logic                     rsp_strobe;
   logic [1:0]               rsp_status;
   logic [LEN_W-1:0]         rsp_length;
   logic signed [DATA_W-1:0] rsp_element;
   logic                     rsp_element_valid;
   logic                     rsp_last;

   seq_cmd_type              cmd_backlog[$];
   rsp_type                  expected_rsp[$];
   logic signed [DATA_W-1:0] shadow_seq[$];
   int                       idle_pct     = 0;
   int                       err_count    = 0;
   int                       quiet_cycles = 0;
   int                       gen_count    = 0;
   bit                       grow_mode    = 1'b1;
   logic                     took_cmd     = 1'b0;

   always #6 clock = ~clock;

   positional_sequence_store u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_value         (req_value),
      .req_position      (req_position),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_length        (rsp_length),
      .rsp_element       (rsp_element),
      .rsp_element_valid (rsp_element_valid),
      .rsp_last          (rsp_last)
   );

   function automatic void push_rsp(status_type status, logic signed [DATA_W-1:0] elem,
                                    logic valid, logic last);
      rsp_type r;
      r.status        = status;
      r.length        = LEN_W'(shadow_seq.size());
      r.element       = elem;
      r.element_valid = valid;
      r.last          = last;
      expected_rsp.push_back(r);
   endfunction

   // updates the shadow sequence and queues the results of one transaction
   function automatic void predict_seq_cmd(seq_cmd_type c);
      int         count;
      int         idx;
      status_type st;
      count = shadow_seq.size();
      st    = ST_OK;
      idx   = 0;
      case (c.command)
         CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
            if (c.command == CMD_INS_BACK) idx = count;
            else if (c.command == CMD_INS_AT) idx = int'(c.position) - 1;
            // position is checked before fullness
            if (c.command == CMD_INS_AT && (c.position == 0 || int'(c.position) > count + 1))
               st = ST_BADPOS;
            else if (count >= DEPTH)
               st = ST_FULL;
            else
               shadow_seq.insert(idx, c.value);
         end
         CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
            if (c.command == CMD_DEL_BACK) idx = count - 1;
            else if (c.command == CMD_DEL_AT) idx = int'(c.position) - 1;
            // empty wins over a bad position
            if (count == 0)
               st = ST_EMPTY;
            else if (c.command == CMD_DEL_AT && (c.position == 0 || int'(c.position) > count))
               st = ST_BADPOS;
            else
               shadow_seq.delete(idx);
         end
         CMD_DUMP: begin
            if (count == 0) begin
               push_rsp(ST_EMPTY, '0, 1'b0, 1'b1);
            end else begin
               foreach (shadow_seq[i]) push_rsp(ST_OK, shadow_seq[i], 1'b1, i == count - 1);
            end
            return;
         end
         default: ;
      endcase
      push_rsp(st, '0, 1'b0, 1'b1);
   endfunction

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
         err_count++;
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      end
   endfunction

   // queues one transaction and tracks the count the store will have after it
   function automatic void add_cmd(cmd_type command, logic signed [DATA_W-1:0] value,
                                   logic [POS_W-1:0] position);
      seq_cmd_type c;
      c.command  = command;
      c.value    = value;
      c.position = position;
      cmd_backlog.push_back(c);
      case (command)
         CMD_INS_FRONT, CMD_INS_BACK: if (gen_count < DEPTH) gen_count++;
         CMD_INS_AT:
            if (position != 0 && int'(position) <= gen_count + 1 && gen_count < DEPTH)
               gen_count++;
         CMD_DEL_FRONT, CMD_DEL_BACK: if (gen_count > 0) gen_count--;
         CMD_DEL_AT:
            if (gen_count > 0 && position != 0 && int'(position) <= gen_count) gen_count--;
         default: ;
      endcase
   endfunction

   task automatic gen_random_cmds(int n);
      int                       roll;
      int                       ins_share;
      cmd_type                  command;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
      for (int k = 0; k < n; k++) begin
         roll      = $urandom_range(99);
         ins_share = grow_mode ? 70 : 30;
         if (roll < 8)
            command = CMD_DUMP;
         else if (roll < 12)
            command = CMD_COUNT;
         else if ($urandom_range(99) < ins_share)
            command = cmd_type'($urandom_range(2));
         else
            command = cmd_type'(3 + $urandom_range(2));

         case ($urandom_range(7))
            0:       value = 32'sh8000_0000;
            1:       value = 32'sh7fff_ffff;
            2:       value = $urandom_range(1) ? 32'sd0 : -32'sd1;
            default: value = $urandom;
         endcase

         position = POS_W'($urandom_range(63));
         if (command == CMD_INS_AT) begin
            if ($urandom_range(5) == 0)
               position = $urandom_range(1) ? 6'd0 : POS_W'($urandom_range(gen_count + 2, 63));
            else
               position = POS_W'($urandom_range(1, gen_count + 1));
         end else if (command == CMD_DEL_AT && gen_count > 0) begin
            if ($urandom_range(5) == 0)
               position = $urandom_range(1) ? 6'd0 : POS_W'($urandom_range(gen_count + 1, 63));
            else
               position = POS_W'($urandom_range(1, gen_count));
         end

         add_cmd(command, value, position);

         // linger a little at full and empty before turning around
         if (grow_mode && gen_count == DEPTH && $urandom_range(3) == 0)
            grow_mode = 1'b0;
         else if (!grow_mode && gen_count == 0 && $urandom_range(2) == 0)
            grow_mode = 1'b1;
      end
   endtask

   // sender pauses here until every transaction is taken and answered
   task automatic wait_drained();
      do begin
         @(negedge clock);
         #1;
      end while (cmd_backlog.size() != 0 || start || expected_rsp.size() != 0);
   endtask

   // driver
   always @(negedge clock) begin
      seq_cmd_type c;
      if (!reset && (!start || took_cmd)) begin
         if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
            c = cmd_backlog.pop_front();
            start        <= 1'b1;
            req_command  <= c.command;
            req_value    <= c.value;
            req_position <= c.position;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor, predictor and scoreboard
   always @(posedge clock) begin
      rsp_type     exp_r;
      seq_cmd_type c;
      if (reset) begin
         took_cmd     <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_rsp.size() == 0) begin
               err_count++;
               $error("result with nothing expected: status %0d length %0d element 0x%0h",
                      rsp_status, rsp_length, rsp_element);
            end else begin
               exp_r = expected_rsp.pop_front();
               check_field("rsp_status", 32'(exp_r.status), 32'(rsp_status));
               check_field("rsp_length", 32'(exp_r.length), 32'(rsp_length));
               check_field("rsp_element", exp_r.element, rsp_element);
               check_field("rsp_element_valid", 32'(exp_r.element_valid),
                           32'(rsp_element_valid));
               check_field("rsp_last", 32'(exp_r.last), 32'(rsp_last));
            end
         end
         // results of an earlier transaction are checked before this one is predicted
         if (start && !busy) begin
            c.command  = cmd_type'(req_command);
            c.value    = req_value;
            c.position = req_position;
            predict_seq_cmd(c);
         end
         took_cmd     <= start && !busy;
         quiet_cycles <= ((start && !busy) || rsp_strobe) ? 0 : quiet_cycles + 1;
      end
   end

   // watchdog
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("positional_sequence_store test failed");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed opening: empty store, bad positions, value extremes
      idle_pct = 0;
      add_cmd(CMD_DUMP,      32'sd0,         6'd0);
      add_cmd(CMD_COUNT,     32'sd0,         6'd0);
      add_cmd(CMD_DEL_FRONT, 32'sd0,         6'd0);
      add_cmd(CMD_DEL_BACK,  32'sd0,         6'd0);
      add_cmd(CMD_DEL_AT,    32'sd0,         6'd63);
      add_cmd(CMD_INS_AT,    32'sd5,         6'd0);
      add_cmd(CMD_INS_AT,    32'sd6,         6'd2);
      add_cmd(CMD_INS_FRONT, 32'sh7fff_ffff, 6'd0);
      add_cmd(CMD_INS_BACK,  32'sh8000_0000, 6'd63);
      add_cmd(CMD_INS_AT,    -32'sd1,        6'd2);
      add_cmd(CMD_INS_AT,    32'sd0,         6'd4);
      add_cmd(CMD_INS_AT,    32'sd7,         6'd63);
      add_cmd(CMD_DEL_AT,    32'sd0,         6'd0);
      add_cmd(CMD_DEL_AT,    32'sd0,         6'd5);
      add_cmd(CMD_DUMP,      32'sd0,         6'd0);
      add_cmd(CMD_DEL_AT,    32'sd0,         6'd2);
      add_cmd(CMD_DEL_FRONT, 32'sd0,         6'd0);
      add_cmd(CMD_DEL_BACK,  32'sd0,         6'd0);
      add_cmd(CMD_COUNT,     32'sd0,         6'd0);
      add_cmd(CMD_DUMP,      32'sd0,         6'd0);
      add_cmd(CMD_DEL_AT,    32'sd0,         6'd1);
      add_cmd(CMD_DUMP,      32'sd0,         6'd0);
      wait_drained();

      idle_pct = 15;
      gen_random_cmds(130);
      wait_drained();

      idle_pct = 79;
      gen_random_cmds(130);
      wait_drained();

      idle_pct = 0;
      gen_random_cmds(140);
      wait_drained();

      repeat (TAIL_CYCLES) @(negedge clock);
      if (err_count == 0) begin
         $display("positional_sequence_store test passed");
      end else begin
         $display("positional_sequence_store test failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/pss_pkg.sv
hdl/pss_ram.sv
hdl/pss_ctrl.sv
hdl/positional_sequence_store.sv
hdl/pss_checker.sv
tb/tb_top.sv
